// ===== src/pfas_pkg.sv =====
package pfas_pkg;

    localparam int WORD_BITS       = 64;
    localparam int OFF_BITS        = 6;
    localparam int ELEM_BITS_DEF   = 5;
    localparam int DEPTH_WORDS_DEF = 1024;

    localparam int MODE_W  = 2;
    localparam int POS_W   = 14;
    localparam int VAL_W   = 5;
    localparam int COUNT_W = 14;
    localparam int STAT_W  = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic capture;
        logic issue;
        logic commit;
    } t_dp_cmd;

endpackage

// ===== src/packed_field_array_store.sv =====
// Packed field array store: 5-bit symbol codes packed densely into 64-bit words.
// Slave channel (i_s_*) takes one operation per item: append, write at position
// or read at position. Master channel (o_m_*) returns exactly one result per item
// with the read value, the element count after the operation and a status.
// An item is captured, read from the word memory in S_READ and its result
// registered in S_WRITE; a new item is taken only as the last one commits, due
// to the read-then-write of the word memory, split into an even and an odd bank
// so that both words an element can touch are read and written back together.
// Reset clears the element count and fill offset; word memory is not cleared,
// since no valid read touches a word that an append has not written.
// Position at or beyond the count gives status 1; append to a full store gives
// status 2; neither changes the store.
// When the receiver stalls the finished result is held on o_m_tdata, the block
// keeps the next item, already read, waiting before its write-back and drops
// o_s_tready until the result is taken.
module packed_field_array_store #(
    parameter int ELEM_BITS   = pfas_pkg::ELEM_BITS_DEF,
    parameter int DEPTH_WORDS = pfas_pkg::DEPTH_WORDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // mode[1:0], position[15:2], element_value[20:16]
    input  logic [pfas_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // read_value[4:0], element_count[18:5], status[20:19]
    output logic [pfas_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int MW = pfas_pkg::MODE_W;
    localparam int PW = pfas_pkg::POS_W;
    localparam int VW = pfas_pkg::VAL_W;
    localparam int CW = pfas_pkg::COUNT_W;
    localparam int SW = pfas_pkg::STAT_W;

    pfas_pkg::t_dp_cmd cmd;
    logic [MW-1:0]     mode;
    logic [PW-1:0]     position;
    logic [VW-1:0]     element_value;
    logic [VW-1:0]     read_value;
    logic [CW-1:0]     element_count;
    logic [SW-1:0]     status;

    assign mode          = i_s_tdata[MW-1:0];
    assign position      = i_s_tdata[MW+PW-1:MW];
    assign element_value = i_s_tdata[MW+PW+VW-1:MW+PW];

    pfas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    pfas_datapath #(
        .ELEM_BITS   (ELEM_BITS),
        .DEPTH_WORDS (DEPTH_WORDS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_mode          (mode),
        .i_position      (position),
        .i_element_value (element_value),
        .o_read_value    (read_value),
        .o_element_count (element_count),
        .o_status        (status)
    );

    assign o_m_tdata = {{(pfas_pkg::OUT_TDATA_W - VW - CW - SW){1'b0}},
                        status, element_count, read_value};

endmodule

// ===== src/pfas_ram.sv =====
module pfas_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/pfas_ctrl.sv =====
module pfas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output pfas_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   s_ready;
    logic   capture;
    logic   commit;

    assign out_free = !r_out_valid || i_m_tready;
    assign s_ready  = (r_state == S_IDLE) || ((r_state == S_WRITE) && out_free);
    assign capture  = i_s_tvalid && s_ready;
    assign commit   = (r_state == S_WRITE) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (capture) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (commit) begin
                    n_state = capture ? S_READ : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready    = s_ready;
    assign o_m_tvalid    = r_out_valid;
    assign o_cmd.capture = capture;
    assign o_cmd.issue   = (r_state == S_READ);
    assign o_cmd.commit  = commit;

endmodule

// ===== src/pfas_datapath.sv =====
module pfas_datapath #(
    parameter int ELEM_BITS   = pfas_pkg::ELEM_BITS_DEF,
    parameter int DEPTH_WORDS = pfas_pkg::DEPTH_WORDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pfas_pkg::t_dp_cmd            i_cmd,
    input  logic [pfas_pkg::MODE_W-1:0]  i_mode,
    input  logic [pfas_pkg::POS_W-1:0]   i_position,
    input  logic [pfas_pkg::VAL_W-1:0]   i_element_value,
    output logic [pfas_pkg::VAL_W-1:0]   o_read_value,
    output logic [pfas_pkg::COUNT_W-1:0] o_element_count,
    output logic [pfas_pkg::STAT_W-1:0]  o_status
);

    localparam int    WB         = pfas_pkg::WORD_BITS;
    localparam int    OB         = pfas_pkg::OFF_BITS;
    localparam int    CAT_W      = 2 * WB;
    localparam longint CAPACITY  = (longint'(DEPTH_WORDS) * WB) / ELEM_BITS;
    localparam int    CNT_W      = $clog2(CAPACITY + 1);
    localparam int    IDX_W      = (CNT_W > pfas_pkg::POS_W) ? CNT_W : pfas_pkg::POS_W;
    localparam int    BP_W       = IDX_W + OB;
    localparam int    BANK_DEPTH = DEPTH_WORDS / 2 + 1;
    localparam int    BANK_AW    = $clog2(BANK_DEPTH);
    localparam logic [CAT_W-1:0] ELEM_MASK = (CAT_W'(1) << ELEM_BITS) - CAT_W'(1);

    logic [pfas_pkg::MODE_W-1:0]  r_mode;
    logic [pfas_pkg::POS_W-1:0]   r_pos;
    logic [pfas_pkg::VAL_W-1:0]   r_val;
    logic [CNT_W-1:0]             r_count;
    logic [OB-1:0]                r_fill_offset;

    logic [OB-1:0]                r_off;
    logic                         r_lo_bank;
    logic                         r_spans;
    logic                         r_wr_ok;
    logic                         r_append_ok;
    logic                         r_read_ok;
    logic [pfas_pkg::STAT_W-1:0]  r_stat_q;
    logic [BANK_AW-1:0]           r_even_addr;
    logic [BANK_AW-1:0]           r_odd_addr;

    logic [pfas_pkg::VAL_W-1:0]   r_read_value;
    logic [pfas_pkg::COUNT_W-1:0] r_element_count;
    logic [pfas_pkg::STAT_W-1:0]  r_status;

    logic                         is_append;
    logic                         is_access;
    logic [IDX_W-1:0]             idx;
    logic [BP_W-1:0]              bitpos;
    logic [IDX_W-1:0]             widx;
    logic [OB-1:0]                off;
    logic [BANK_AW-1:0]           even_addr;
    logic [BANK_AW-1:0]           odd_addr;
    logic                         full;
    logic                         range_bad;
    logic [pfas_pkg::STAT_W-1:0]  stat;

    logic [WB-1:0]                even_rd;
    logic [WB-1:0]                odd_rd;
    logic [WB-1:0]                w_lo;
    logic [WB-1:0]                w_hi;
    logic [CAT_W-1:0]             base;
    logic [CAT_W-1:0]             val_sh;
    logic [CAT_W-1:0]             merged;
    logic [CAT_W-1:0]             extracted;
    logic                         wr_lo;
    logic                         wr_hi;
    logic                         even_wr;
    logic                         odd_wr;
    logic [WB-1:0]                even_wdata;
    logic [WB-1:0]                odd_wdata;

    // address and status phase
    always_comb begin
        is_append = (r_mode == pfas_pkg::MODE_APPEND);
        is_access = (r_mode == pfas_pkg::MODE_WRITE) || (r_mode == pfas_pkg::MODE_READ);
        idx       = is_append ? IDX_W'(r_count) : IDX_W'(r_pos);
        bitpos    = BP_W'(idx) * BP_W'(ELEM_BITS);
        widx      = bitpos[BP_W-1:OB];
        off       = is_append ? r_fill_offset : bitpos[OB-1:0];
        odd_addr  = BANK_AW'(widx >> 1);
        even_addr = BANK_AW'((widx >> 1) + IDX_W'(widx[0]));
        full      = (r_count >= CNT_W'(CAPACITY));
        range_bad = (IDX_W'(r_pos) >= IDX_W'(r_count));
        stat      = pfas_pkg::ST_OK;
        if (is_append && full) begin
            stat = pfas_pkg::ST_FULL;
        end else if (is_access && range_bad) begin
            stat = pfas_pkg::ST_RANGE;
        end
    end

    // merge and extract phase
    always_comb begin
        w_lo      = r_lo_bank ? odd_rd : even_rd;
        w_hi      = r_lo_bank ? even_rd : odd_rd;
        if (r_append_ok) begin
            base = {{WB{1'b0}}, (r_off == '0) ? {WB{1'b0}} : w_lo};
        end else begin
            base = {w_hi, w_lo};
        end
        val_sh    = (CAT_W'(r_val) & ELEM_MASK) << r_off;
        merged    = (base & ~(ELEM_MASK << r_off)) | val_sh;
        extracted = ({w_hi, w_lo} >> r_off) & ELEM_MASK;
        wr_lo     = i_cmd.commit && r_wr_ok;
        wr_hi     = wr_lo && r_spans;
        even_wr   = r_lo_bank ? wr_hi : wr_lo;
        odd_wr    = r_lo_bank ? wr_lo : wr_hi;
        even_wdata = r_lo_bank ? merged[CAT_W-1:WB] : merged[WB-1:0];
        odd_wdata  = r_lo_bank ? merged[WB-1:0] : merged[CAT_W-1:WB];
    end

    pfas_ram #(
        .WIDTH (WB),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .i_clk     (i_clk),
        .i_wr_en   (even_wr),
        .i_wr_addr (r_even_addr),
        .i_wr_data (even_wdata),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (even_addr),
        .o_rd_data (even_rd)
    );

    pfas_ram #(
        .WIDTH (WB),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .i_clk     (i_clk),
        .i_wr_en   (odd_wr),
        .i_wr_addr (r_odd_addr),
        .i_wr_data (odd_wdata),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (odd_addr),
        .o_rd_data (odd_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_fill_offset <= '0;
        end else if (i_cmd.commit && r_append_ok) begin
            r_count       <= r_count + CNT_W'(1);
            r_fill_offset <= r_fill_offset + OB'(ELEM_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_pos  <= i_position;
            r_val  <= i_element_value;
        end
        if (i_cmd.issue) begin
            r_off       <= off;
            r_lo_bank   <= widx[0];
            r_spans     <= ((OB + 1)'(off) + (OB + 1)'(ELEM_BITS)) > (OB + 1)'(WB);
            r_append_ok <= is_append && (stat == pfas_pkg::ST_OK);
            r_read_ok   <= (r_mode == pfas_pkg::MODE_READ) && (stat == pfas_pkg::ST_OK);
            r_wr_ok     <= (is_append || (r_mode == pfas_pkg::MODE_WRITE))
                           && (stat == pfas_pkg::ST_OK);
            r_stat_q    <= stat;
            r_even_addr <= even_addr;
            r_odd_addr  <= odd_addr;
        end
        if (i_cmd.commit) begin
            r_read_value    <= r_read_ok ? pfas_pkg::VAL_W'(extracted) : '0;
            r_element_count <= r_append_ok ? pfas_pkg::COUNT_W'(r_count + CNT_W'(1))
                                           : pfas_pkg::COUNT_W'(r_count);
            r_status        <= r_stat_q;
        end
    end

    assign o_read_value    = r_read_value;
    assign o_element_count = r_element_count;
    assign o_status        = r_status;

endmodule
